@@ rtl/pkxor_pkg.sv @@
// ----------------------------------------------------------------------------
// pkxor_pkg
// Shared types and constants of the password-keyed XOR stream cipher core.
// ----------------------------------------------------------------------------
package pkxor_pkg;

   localparam int KEY_BYTES_DEF = 32;
   localparam int CMD_W         = 2;
   localparam int DATA_W        = 8;

   localparam logic [1:0] ABS_LAST  = 2'd2;
   localparam logic [1:0] PASS_LAST = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_ABSORB  = 2'd0,
      CMD_FINAL   = 2'd1,
      CMD_CRYPT   = 2'd2,
      CMD_RESTART = 2'd3
   } cmd_type;

   typedef enum logic [7:0] {
      ST_IDLE    = 8'b0000_0001,
      ST_ABS_RD  = 8'b0000_0010,
      ST_ABS_WR  = 8'b0000_0100,
      ST_FIN_A   = 8'b0000_1000,
      ST_FIN_B   = 8'b0001_0000,
      ST_FIN_C   = 8'b0010_0000,
      ST_FIN_RUN = 8'b0100_0000,
      ST_CRYPT   = 8'b1000_0000
   } state_type;

endpackage

@@ rtl/password_keyed_xor_stream_cipher_core.sv @@
// ----------------------------------------------------------------------------
// password_keyed_xor_stream_cipher_core
// Password-keyed XOR stream cipher: absorb, finalize, crypt and restart beats.
// ----------------------------------------------------------------------------
// One beat is handled at a time. Restart clears the data position, crypt
// reads the key store, then loads the result register, absorb makes three
// read-modify-write updates of the one-read, one-write accumulator memory,
// and finalize makes three set-up reads, then mixes one byte per cycle
// through the accumulator memory, the last pass also writing the key store.
// No clearing pass after reset: per-entry valid flags make unwritten bytes
// read as zero. A finished result sits in the output register while the
// next beat is taken; a crypt beat that follows holds in ST_CRYPT until
// that result has gone.
module password_keyed_xor_stream_cipher_core #(
   parameter int KEY_BYTES = pkxor_pkg::KEY_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pkxor_pkg::DATA_W-1:0]   req_tdata,   // [7:0] data_byte
   input  logic [pkxor_pkg::CMD_W-1:0]    req_tuser,   // [1:0] cmd
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [pkxor_pkg::DATA_W-1:0]   rsp_tdata    // [7:0] result_byte
);
   import pkxor_pkg::*;

   localparam int IDX_W = $clog2(KEY_BYTES);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_BYTES - 1);
   localparam logic [IDX_W-1:0] STEP7    = IDX_W'(7 % KEY_BYTES);
   localparam logic [IDX_W-1:0] STEP13   = IDX_W'(13 % KEY_BYTES);
   localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

   function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] s);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, a} + {1'b0, s};
      if (sum >= SUM_W'(KEY_BYTES)) begin
         sum = sum - SUM_W'(KEY_BYTES);
      end
      return sum[IDX_W-1:0];
   endfunction

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        absorb_count_ff, absorb_count_in;
   logic [IDX_W-1:0]        pos7_ff, pos7_in;
   logic [IDX_W-1:0]        pos13_ff, pos13_in;
   logic [IDX_W-1:0]        data_pos_ff, data_pos_in;
   logic [1:0]              step_ff, step_in;
   logic [DATA_W-1:0]       byte_ff, byte_in;
   logic [IDX_W-1:0]        fin_idx_ff, fin_idx_in;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   logic [1:0]              pass_ff, pass_in;
   logic [DATA_W-1:0]       prv_ff, prv_in;
   logic [DATA_W-1:0]       cur_ff, cur_in;
   logic [KEY_BYTES-1:0]    acc_vld_ff, acc_vld_in;
   logic                    key_vld_ff, key_vld_in;
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [DATA_W-1:0]       rsp_tdata_ff, rsp_tdata_in;

   logic [DATA_W-1:0]       acc_mem [KEY_BYTES];
   logic [DATA_W-1:0]       key_mem [KEY_BYTES];
   logic [DATA_W-1:0]       acc_rd_ff;
   logic                    acc_rd_vld_ff;
   logic [DATA_W-1:0]       key_rd_ff;

   logic [IDX_W-1:0]        acc_rd_addr;
   logic                    acc_we;
   logic [IDX_W-1:0]        acc_wr_addr;
   logic [DATA_W-1:0]       acc_wr_data;
   logic                    acc_clr;
   logic                    key_we;
   logic [DATA_W-1:0]       acc_rd_eff;
   logic [DATA_W-1:0]       key_eff;
   logic [DATA_W-1:0]       mix_val;
   logic [IDX_W-1:0]        abs_addr;
   logic [DATA_W-1:0]       abs_delta;
   logic                    fin_last;
   logic                    req_accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign acc_rd_eff = acc_rd_vld_ff ? acc_rd_ff : '0;
   assign key_eff    = key_vld_ff ? key_rd_ff : '0;
   assign mix_val    = cur_ff ^ {2'b00, acc_rd_eff[7:2]} ^ {prv_ff[4:0], 3'b000};
   assign fin_last   = (pass_ff == PASS_LAST) && (fin_idx_ff == LAST_IDX);

   always_comb begin
      case (step_ff)
         2'd0: begin
            abs_addr  = absorb_count_ff;
            abs_delta = byte_ff;
         end
         2'd1: begin
            abs_addr  = pos7_ff;
            abs_delta = {1'b0, byte_ff[7:1]};
         end
         default: begin
            abs_addr  = pos13_ff;
            abs_delta = {byte_ff[6:0], 1'b0};
         end
      endcase
   end

   always_comb begin
      state_in        = state_ff;
      absorb_count_in = absorb_count_ff;
      pos7_in         = pos7_ff;
      pos13_in        = pos13_ff;
      data_pos_in     = data_pos_ff;
      step_in         = step_ff;
      byte_in         = byte_ff;
      fin_idx_in      = fin_idx_ff;
      rd_idx_in       = rd_idx_ff;
      pass_in         = pass_ff;
      prv_in          = prv_ff;
      cur_in          = cur_ff;
      key_vld_in      = key_vld_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in    = rsp_tdata_ff;
      acc_rd_addr     = '0;
      acc_we          = 1'b0;
      acc_wr_addr     = '0;
      acc_wr_data     = '0;
      acc_clr         = 1'b0;
      key_we          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (cmd_type'(req_tuser))
                  CMD_ABSORB: begin
                     byte_in  = req_tdata;
                     step_in  = 2'd0;
                     state_in = ST_ABS_RD;
                  end
                  CMD_FINAL: begin
                     state_in = ST_FIN_A;
                  end
                  CMD_CRYPT: begin
                     byte_in  = req_tdata;
                     state_in = ST_CRYPT;
                  end
                  CMD_RESTART: begin
                     data_pos_in = '0;
                  end
               endcase
            end
         end
         ST_ABS_RD: begin
            acc_rd_addr = abs_addr;
            state_in    = ST_ABS_WR;
         end
         ST_ABS_WR: begin
            acc_we      = 1'b1;
            acc_wr_addr = abs_addr;
            acc_wr_data = acc_rd_eff ^ abs_delta;
            if (step_ff == ABS_LAST) begin
               absorb_count_in = add_mod(absorb_count_ff, ONE_IDX);
               pos7_in         = add_mod(pos7_ff, STEP7);
               pos13_in        = add_mod(pos13_ff, STEP13);
               state_in        = ST_IDLE;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_ABS_RD;
            end
         end
         ST_FIN_A: begin
            acc_rd_addr = LAST_IDX;
            state_in    = ST_FIN_B;
         end
         ST_FIN_B: begin
            acc_rd_addr = '0;
            prv_in      = acc_rd_eff;
            rd_idx_in   = ONE_IDX;
            state_in    = ST_FIN_C;
         end
         ST_FIN_C: begin
            acc_rd_addr = rd_idx_ff;
            rd_idx_in   = add_mod(rd_idx_ff, ONE_IDX);
            cur_in      = acc_rd_eff;
            fin_idx_in  = '0;
            pass_in     = 2'd0;
            state_in    = ST_FIN_RUN;
         end
         ST_FIN_RUN: begin
            acc_rd_addr = rd_idx_ff;
            rd_idx_in   = add_mod(rd_idx_ff, ONE_IDX);
            acc_we      = 1'b1;
            acc_wr_addr = fin_idx_ff;
            acc_wr_data = mix_val;
            key_we      = (pass_ff == PASS_LAST);
            prv_in      = mix_val;
            cur_in      = acc_rd_eff;
            fin_idx_in  = add_mod(fin_idx_ff, ONE_IDX);
            if (fin_idx_ff == LAST_IDX) begin
               pass_in = pass_ff + 2'd1;
            end
            if (fin_last) begin
               acc_clr         = 1'b1;
               key_vld_in      = 1'b1;
               absorb_count_in = '0;
               pos7_in         = '0;
               pos13_in        = '0;
               data_pos_in     = '0;
               state_in        = ST_IDLE;
            end
         end
         ST_CRYPT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = byte_ff ^ key_eff;
               data_pos_in   = add_mod(data_pos_ff, ONE_IDX);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      acc_vld_in = acc_vld_ff;
      if (acc_we) begin
         acc_vld_in[acc_wr_addr] = 1'b1;
      end
      if (acc_clr) begin
         acc_vld_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         absorb_count_ff <= '0;
         pos7_ff         <= '0;
         pos13_ff        <= '0;
         data_pos_ff     <= '0;
         step_ff         <= '0;
         fin_idx_ff      <= '0;
         rd_idx_ff       <= '0;
         pass_ff         <= '0;
         acc_vld_ff      <= '0;
         key_vld_ff      <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         state_ff        <= state_in;
         absorb_count_ff <= absorb_count_in;
         pos7_ff         <= pos7_in;
         pos13_ff        <= pos13_in;
         data_pos_ff     <= data_pos_in;
         step_ff         <= step_in;
         fin_idx_ff      <= fin_idx_in;
         rd_idx_ff       <= rd_idx_in;
         pass_ff         <= pass_in;
         acc_vld_ff      <= acc_vld_in;
         key_vld_ff      <= key_vld_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      prv_ff       <= prv_in;
      cur_ff       <= cur_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // accumulator memory: one read, one write port
   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_wr_addr] <= acc_wr_data;
      end
      acc_rd_ff     <= acc_mem[acc_rd_addr];
      acc_rd_vld_ff <= acc_vld_ff[acc_rd_addr];
   end

   // key store
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[fin_idx_ff] <= mix_val;
      end
      key_rd_ff <= key_mem[data_pos_ff];
   end

   a_rsp_from_crypt: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_CRYPT))
      else $error("result beat raised outside crypt");

   a_fin_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_RUN) |-> (acc_rd_addr != acc_wr_addr))
      else $error("mixing read and write hit the same byte");

   a_fin_clears_acc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN_RUN) && fin_last |=> (acc_vld_ff == '0) && key_vld_ff
                                               && (data_pos_ff == '0))
      else $error("finalize left accumulator or position behind");

   a_restart_pos: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_tuser == CMD_RESTART) |=> (data_pos_ff == '0))
      else $error("restart did not clear data position");

   a_out_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tready |=> rsp_tvalid_ff && $stable(rsp_tdata_ff))
      else $error("stalled result beat lost");

endmodule

@@ dv/password_keyed_xor_stream_cipher_core_tb.sv @@
// ----------------------------------------------------------------------------
// password_keyed_xor_stream_cipher_core_tb
// Drives absorb, finalize, crypt and restart beats with random gaps and
// output stalls, predicts each result byte from a local copy of the password
// accumulator and key store, and checks the bytes in order.
// ----------------------------------------------------------------------------
module password_keyed_xor_stream_cipher_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pkxor_pkg::*;

   localparam int KB          = KEY_BYTES_DEF;
   localparam int BEAT_TARGET = 1650;
   localparam int N_DIR       = 18;

   typedef struct packed {
      cmd_type           cmd;
      logic [DATA_W-1:0] data;
      bit                typed;
      logic [DATA_W-1:0] want;
   } dir_row_type;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic [CMD_W-1:0]  req_tuser  = '0;   // [1:0] cmd
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;         // [7:0] result_byte

   logic [DATA_W-1:0] pw_acc  [KB];
   logic [DATA_W-1:0] key_tab [KB];
   int                pw_count;
   int                stream_pos;

   logic [DATA_W-1:0] crypt_bytes_due [$];
   logic [DATA_W-1:0] due_byte;
   int                beats_sent = 0;
   int                n_fail     = 0;
   bit                calm_tail  = 1'b0;

   // typed expectations: zero key before any finalize and after an empty one
   dir_row_type dir_rows [N_DIR] = '{
      '{CMD_CRYPT,   8'h00, 1'b1, 8'h00},
      '{CMD_CRYPT,   8'hFF, 1'b1, 8'hFF},
      '{CMD_CRYPT,   8'hA5, 1'b1, 8'hA5},
      '{CMD_RESTART, 8'h00, 1'b0, 8'h00},
      '{CMD_FINAL,   8'h00, 1'b0, 8'h00},
      '{CMD_CRYPT,   8'h5A, 1'b1, 8'h5A},
      '{CMD_ABSORB,  8'hFF, 1'b0, 8'h00},
      '{CMD_ABSORB,  8'h00, 1'b0, 8'h00},
      '{CMD_ABSORB,  8'h80, 1'b0, 8'h00},
      '{CMD_ABSORB,  8'h01, 1'b0, 8'h00},
      '{CMD_FINAL,   8'hFF, 1'b0, 8'h00},
      '{CMD_CRYPT,   8'h00, 1'b0, 8'h00},
      '{CMD_CRYPT,   8'hFF, 1'b0, 8'h00},
      '{CMD_CRYPT,   8'h3C, 1'b0, 8'h00},
      '{CMD_RESTART, 8'hFF, 1'b0, 8'h00},
      '{CMD_CRYPT,   8'h00, 1'b0, 8'h00},
      '{CMD_FINAL,   8'hFF, 1'b0, 8'h00},
      '{CMD_CRYPT,   8'h77, 1'b1, 8'h77}
   };

   password_keyed_xor_stream_cipher_core #(.KEY_BYTES(KB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic void cipher_step(input cmd_type c, input logic [DATA_W-1:0] b,
                                       output bit has_out, output logic [DATA_W-1:0] out);
      int i;
      has_out = 1'b0;
      out     = '0;
      case (c)
         CMD_ABSORB: begin
            i = pw_count;
            pw_acc[i]             ^= b;
            pw_acc[(i * 7) % KB]  ^= b >> 1;
            pw_acc[(i * 13) % KB] ^= b << 1;
            pw_count = (i + 1) % KB;
         end
         CMD_FINAL: begin
            for (int pass = 0; pass < 3; pass++) begin
               for (int p = 0; p < KB; p++) begin
                  pw_acc[p] ^= pw_acc[(p + 1) % KB] >> 2;
                  pw_acc[p] ^= pw_acc[(p + KB - 1) % KB] << 3;
               end
            end
            for (int p = 0; p < KB; p++) begin
               key_tab[p] = pw_acc[p];
               pw_acc[p]  = '0;
            end
            pw_count   = 0;
            stream_pos = 0;
         end
         CMD_CRYPT: begin
            has_out    = 1'b1;
            out        = b ^ key_tab[stream_pos];
            stream_pos = (stream_pos + 1) % KB;
         end
         CMD_RESTART: begin
            stream_pos = 0;
         end
      endcase
   endfunction

   task automatic send_beat(input cmd_type c, input logic [DATA_W-1:0] b,
                            input bit typed, input logic [DATA_W-1:0] want);
      bit                has_out;
      logic [DATA_W-1:0] out;
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      cipher_step(c, b, has_out, out);
      if (has_out)
         crypt_bytes_due.push_back(typed ? want : out);
      beats_sent++;
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (crypt_bytes_due.size() != 0);
   endtask

   // output stalls
   initial begin
      @(posedge clock);
      forever begin
         if (!calm_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crypt_bytes_due.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
               $display("result_byte %02h arrived with none expected", rsp_tdata);
         end else begin
            due_byte = crypt_bytes_due.pop_front();
            if (rsp_tdata !== due_byte) begin
               n_fail++;
               if (n_fail <= 10)
                  $display("result_byte mismatch: expected %02h got %02h",
                           due_byte, rsp_tdata);
            end
         end
      end
   end

   initial begin
      int  n_pw;
      int  n_data;
      bit  mid_drained;
      mid_drained = 1'b0;
      for (int p = 0; p < KB; p++) begin
         pw_acc[p]  = '0;
         key_tab[p] = '0;
      end
      pw_count   = 0;
      stream_pos = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r])
         send_beat(dir_rows[r].cmd, dir_rows[r].data, dir_rows[r].typed, dir_rows[r].want);

      wait_results_drained();

      while (beats_sent < BEAT_TARGET + N_DIR) begin
         if (beats_sent >= BEAT_TARGET + N_DIR - 200)
            calm_tail = 1'b1;
         if (!mid_drained && beats_sent >= BEAT_TARGET / 2) begin
            wait_results_drained();
            mid_drained = 1'b1;
         end
         if ($urandom_range(0, 9) < 7) begin
            // password, finalize, then a run of data with the odd restart
            n_pw = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 80)
                                               : $urandom_range(0, 24);
            repeat (n_pw)
               send_beat(CMD_ABSORB, DATA_W'($urandom), 1'b0, '0);
            send_beat(CMD_FINAL, DATA_W'($urandom), 1'b0, '0);
            n_data = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 70)
                                                 : $urandom_range(1, 32);
            repeat (n_data) begin
               if ($urandom_range(0, 11) == 0)
                  send_beat(CMD_RESTART, DATA_W'($urandom), 1'b0, '0);
               send_beat(CMD_CRYPT, DATA_W'($urandom), 1'b0, '0);
            end
         end else begin
            repeat ($urandom_range(1, 8))
               send_beat(cmd_type'($urandom_range(0, 3)), DATA_W'($urandom), 1'b0, '0);
         end
      end

      wait_results_drained();
      repeat (3 * KB + 8) @(posedge clock);
      if (n_fail == 0 && crypt_bytes_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
